[hdl/cips_pkg.sv]
// ----------------------------------------------------------------------------
// cips_pkg: shared types and constants of the pattern scanner
// Item structs for both channels, queue entry, register indexes and the
// ASCII case fold.
// ----------------------------------------------------------------------------
`default_nettype none

package cips_pkg;

  // Fixed widths of the result and configuration fields, and the queue depth.
  localparam int unsigned ResultBits = 48;
  localparam int unsigned CfgBits    = 64;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_PAT_LEN  = 2'd2;

  // Result kinds.
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [ResultBits-1:0] CountMax = {ResultBits{1'b1}};

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                  result_kind;
    logic [ResultBits-1:0] match_offset;
    logic [ResultBits-1:0] match_total;
    logic                  any_found;
    logic                  run_end;
  } out_item_t;

  // Work handed from the front to the back: a match, an end of data, or both.
  typedef struct packed {
    logic                  hit;
    logic                  last;
    logic [ResultBits-1:0] offset;
    logic [ResultBits-1:0] total;
  } q_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Fold ASCII upper case letters to lower case.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/cips_front.sv]
// ----------------------------------------------------------------------------
// cips_front: byte intake and match detection
// Holds the pattern registers, the folded byte window, the byte offset and
// the match count. Each accepted byte is compared in parallel against the
// aligned pattern, and matches and end-of-data marks are pushed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cips_front import cips_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [CfgBits-1:0]    cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_item_t              in_data,
  input  wire q_status_t             q_stat,
  output      logic                  q_push,
  output      q_entry_t              q_push_entry
);

  localparam int unsigned LW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  // Raw registers and the effective length minus one.
  logic [CfgBits-1:0] pat_low_r, pat_high_r;
  logic [LW-1:0]      lenm1_r;

  // Pattern realigned so that lane j meets window entry j.
  logic [7:0]             aligned_pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_mask;

  // Run state.
  logic [7:0]             win_r   [MAX_PATTERN];
  logic [7:0]             win_nxt [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [ResultBits-1:0]  cnt_r, cnt_nxt;

  logic                   accept;
  logic                   pos_ok;
  logic                   hit;
  logic [MAX_PATTERN-1:0] lane_ok;
  logic [OFFSET_BITS-1:0] off_full;
  logic [127:0]           pat_all;

  // Configuration writes; the length is clamped as it is stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      lenm1_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN: begin
          if (cfg_data[4:0] == 5'd0) begin
            lenm1_r <= '0;
          end else if (32'(cfg_data[4:0]) > MAX_PATTERN) begin
            lenm1_r <= LW'(MAX_PATTERN - 1);
          end else begin
            lenm1_r <= LW'(cfg_data[4:0] - 5'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Aligned pattern: lane j holds pattern byte (length - 1 - j), folded.
  // It is derived straight from the registers, so a write takes effect on
  // the very next byte.
  assign pat_all = {pat_high_r, pat_low_r};

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      aligned_pat[j] = '0;
      lane_mask[j]   = (j <= 32'(lenm1_r));
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (i + j == 32'(lenm1_r)) begin
          aligned_pat[j] = fold_byte(pat_all[8*i +: 8]);
        end
      end
    end
  end

  // Intake handshake: a byte is taken while the queue has room.
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Shifted window with the new folded byte in entry 0.
  always_comb begin
    win_nxt[0] = fold_byte(in_data.data_byte);
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Parallel compare against all active lanes.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      lane_ok[j] = !lane_mask[j] || (win_nxt[j] == aligned_pat[j]);
    end
  end

  assign pos_ok   = (pos_r >= OFFSET_BITS'(lenm1_r));
  assign hit      = pos_ok && (&lane_ok);
  assign off_full = pos_r - OFFSET_BITS'(lenm1_r);

  // Saturating offset and count.
  always_comb begin
    pos_nxt = (pos_r != PosMax) ? pos_r + 1'b1 : pos_r;
    cnt_nxt = (hit && cnt_r != CountMax) ? cnt_r + 1'b1 : cnt_r;
  end

  // Run state update; a final byte starts a new run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_r[j] <= '0;
      end
    end else if (accept) begin
      if (in_data.final_byte) begin
        pos_r <= '0;
        cnt_r <= '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
          win_r[j] <= '0;
        end
      end else begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
        for (int j = 0; j < MAX_PATTERN; j++) begin
          win_r[j] <= win_nxt[j];
        end
      end
    end
  end

  // Work for the back side.
  assign q_push              = accept && (hit || in_data.final_byte);
  assign q_push_entry.hit    = hit;
  assign q_push_entry.last   = in_data.final_byte;
  assign q_push_entry.offset = ResultBits'(off_full);
  assign q_push_entry.total  = cnt_nxt;

endmodule

`default_nettype wire

[hdl/cips_queue.sv]
// ----------------------------------------------------------------------------
// cips_queue: work queue between front and back
// A small first-in first-out queue of pending match and summary work.
// ----------------------------------------------------------------------------
`default_nettype none

module cips_queue import cips_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output      q_entry_t head,
  output      q_status_t stat
);

  localparam int unsigned PW = $clog2(QueueDepth);

  q_entry_t      slot_r [QueueDepth];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   fill_r, fill_nxt;

  assign stat.full  = (fill_r == (PW+1)'(QueueDepth));
  assign stat.empty = (fill_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[hdl/cips_back.sv]
// ----------------------------------------------------------------------------
// cips_back: result formatting and output register
// Turns each queue entry into a match report, a summary, or both in that
// order, and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cips_back import cips_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_entry_t  head,
  input  wire q_status_t q_stat,
  output      logic      pop,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r, res_nxt;
  logic      sent_r, sent_nxt;
  logic      load;
  logic      emit_match;

  // The output register can take a new result when it is empty or drains.
  assign load       = (!out_valid_r || out_ready) && !q_stat.empty;
  assign emit_match = head.hit && !sent_r;

  // Choose the next result from the head entry.
  always_comb begin
    res_nxt.match_total = head.total;
    res_nxt.any_found   = (head.total != '0);
    if (emit_match) begin
      res_nxt.result_kind  = KIND_MATCH;
      res_nxt.match_offset = head.offset;
      res_nxt.run_end      = !head.last;
    end else begin
      res_nxt.result_kind  = KIND_SUMMARY;
      res_nxt.match_offset = '0;
      res_nxt.run_end      = 1'b1;
    end
  end

  // An entry with both a match and an end of data stays for a second result.
  always_comb begin
    pop      = 1'b0;
    sent_nxt = sent_r;
    if (load) begin
      if (emit_match && head.last) begin
        sent_nxt = 1'b1;
      end else begin
        pop      = 1'b1;
        sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hdl/case_insensitive_pattern_scanner_top.sv]
// ----------------------------------------------------------------------------
// case_insensitive_pattern_scanner_top: case-insensitive substring search
// Reports the start offset of every occurrence of a pattern in a byte
// stream, then a summary after the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Write the pattern bytes and length on the cfg_ port while no data is in
//   flight. Send data one byte per item on the in_ channel; mark the last
//   byte with final_byte. Results leave on the out_ channel: a match report
//   per occurrence, and after the last byte a summary with the match count.
// Timing:
//   One byte is accepted per cycle while the work queue has room. The window
//   compare is done in parallel in the cycle of acceptance; the first result
//   of a byte passes through the work queue, then the output register. A last
//   byte that also completes a match yields two results, match report first.
// Flow control:
//   A four-entry work queue sits between intake and the output register.
//   When the receiver stalls, the queue fills and in_ready drops once it
//   is full; nothing is lost.
// Reset:
//   Clears the window, offset, count and queue; pattern registers return to
//   a single zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_pattern_scanner_top import cips_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [CfgBits-1:0]    cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_item_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_item_t             out_data
);

  q_status_t q_stat;
  logic      q_push;
  q_entry_t  q_push_entry;
  logic      q_pop;
  q_entry_t  q_head;

  // Intake and compare.
  cips_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  // Work queue.
  cips_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // Result output.
  cips_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("work queue overflow");

  // The back never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("work queue underflow");

  // A summary always closes the results of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_SUMMARY) |-> out_data.run_end)
    else $error("summary without run end");

  // The found flag agrees with the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.any_found == (out_data.match_total != '0)))
    else $error("found flag disagrees with count");

endmodule

`default_nettype wire
